// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition in this cycle implies consequence in the same cycle
`define GS3_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition in this cycle implies consequence in the next cycle
`define GS3_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define GS3_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define GS3_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- sv/gs3_pkg.sv -----
// ----------------------------------------------------------------------------
// gs3_pkg
// widths and types shared by the gram-schmidt pipeline
// ----------------------------------------------------------------------------
package gs3_pkg;

   localparam int DATA_W = 32;   // q16.16 in, q2.30 out
   localparam int FRAC_W = 30;   // fraction bits of a unit vector entry
   localparam int WIDE_W = 36;   // signed remainder components
   localparam int MAG_W  = 35;   // magnitude of a remainder component
   localparam int POS_W  = 6;
   localparam int BMAG_W = 30;   // scaled magnitude, below 2^30
   localparam int SQR_W  = 63;   // square root working width
   localparam int ROOT_W = 31;
   localparam int QUO_W  = 31;

   typedef logic [2:0][DATA_W-1:0] vec3_type;
   typedef logic [2:0][WIDE_W-1:0] wvec3_type;

   typedef struct packed {
      logic valid;
      logic zero;
   } gs3_flow_type;

endpackage

// ----- sv/gs3_norm.sv -----
// ----------------------------------------------------------------------------
// gs3_norm
// pipelined normalisation of one vector to a q2.30 unit vector
// ----------------------------------------------------------------------------
module gs3_norm
   import gs3_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  wvec3_type           in_vec,
   input  logic [SIDE_W-1:0]   in_side,
   output gs3_flow_type        out_flow,
   output vec3_type            out_vec,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int SQ_STEPS = (SQR_W + 1) / 2;
   localparam int DV_STEPS = QUO_W;
   localparam int SQ_BASE  = 4;
   localparam int DV_BASE  = SQ_BASE + SQ_STEPS + 1;
   localparam int LAST     = DV_BASE + DV_STEPS + 1;
   localparam int NST      = LAST + 1;
   localparam int TOP_BIT  = BMAG_W - 1;
   localparam int DIV_W    = BMAG_W + FRAC_W + 1;

   typedef logic [2:0][BMAG_W-1:0] bm3_type;
   typedef logic [2:0][QUO_W-1:0]  q3_type;

   function automatic logic [POS_W-1:0] lead_pos(input logic [MAG_W-1:0] x);
      logic [POS_W-1:0] p;
      p = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (x[b]) p = POS_W'(b);
      end
      return p;
   endfunction

   logic [NST-1:0]             vld_ff;
   logic [NST-1:0][SIDE_W-1:0] side_ff;
   logic [NST-1:0][2:0]        sgn_ff;
   logic [NST-1:0]             zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff <= {side_ff[NST-2:0], in_side};
         sgn_ff  <= {sgn_ff[NST-2:0],
                     in_vec[2][WIDE_W-1], in_vec[1][WIDE_W-1], in_vec[0][WIDE_W-1]};
         zero_ff <= {zero_ff[NST-2:0], in_vec == '0};
      end
   end

   // magnitudes and largest magnitude
   logic [2:0][MAG_W-1:0] mag_a_in, mag_a_ff, mag_b_ff;
   logic [MAG_W-1:0]      max01, max_a_in, max_a_ff;
   logic [POS_W-1:0]      pos_b_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (in_vec[i][WIDE_W-1]) begin
            mag_a_in[i] = MAG_W'(~in_vec[i] + 1'b1);
         end else begin
            mag_a_in[i] = in_vec[i][MAG_W-1:0];
         end
      end
      max01    = (mag_a_in[0] > mag_a_in[1]) ? mag_a_in[0] : mag_a_in[1];
      max_a_in = (max01 > mag_a_in[2]) ? max01 : mag_a_in[2];
   end

   // scale so the largest magnitude lands in [2^29, 2^30)
   bm3_type                        bm_c_in, bm_c_ff, bm_d_ff;
   logic [2:0][2*BMAG_W-1:0]       sq_d_ff;
   logic [MAG_W+BMAG_W-1:0]        lwide;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lwide = {{BMAG_W{1'b0}}, mag_b_ff[i]} << (POS_W'(TOP_BIT) - pos_b_ff);
         if (pos_b_ff >= POS_W'(TOP_BIT)) begin
            bm_c_in[i] = BMAG_W'(mag_b_ff[i] >> (pos_b_ff - POS_W'(TOP_BIT)));
         end else begin
            bm_c_in[i] = lwide[BMAG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_a_ff <= mag_a_in;
         max_a_ff <= max_a_in;
         mag_b_ff <= mag_a_ff;
         pos_b_ff <= lead_pos(max_a_ff);
         bm_c_ff  <= bm_c_in;
         bm_d_ff  <= bm_c_ff;
         for (int i = 0; i < 3; i++) begin
            sq_d_ff[i] <= bm_c_ff[i] * bm_c_ff[i];
         end
      end
   end

   // bit-per-stage square root of the sum of squares
   logic [SQR_W-1:0] sq_n_ff  [SQ_STEPS+1];
   logic [SQR_W-1:0] sq_r_ff  [SQ_STEPS+1];
   bm3_type          sq_bm_ff [SQ_STEPS+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_n_ff[0]  <= SQR_W'(sq_d_ff[0]) + SQR_W'(sq_d_ff[1]) + SQR_W'(sq_d_ff[2]);
         sq_r_ff[0]  <= '0;
         sq_bm_ff[0] <= bm_d_ff;
      end
   end

   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
      localparam logic [SQR_W-1:0] BIT_J = SQR_W'(1) << (SQR_W - 1 - 2 * j);
      logic [SQR_W-1:0] trial;
      logic [SQR_W-1:0] n_in, r_in;

      always_comb begin
         trial = sq_r_ff[j] + BIT_J;
         if (sq_n_ff[j] >= trial) begin
            n_in = sq_n_ff[j] - trial;
            r_in = (sq_r_ff[j] >> 1) + BIT_J;
         end else begin
            n_in = sq_n_ff[j];
            r_in = sq_r_ff[j] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            sq_n_ff[j+1]  <= n_in;
            sq_r_ff[j+1]  <= r_in;
            sq_bm_ff[j+1] <= sq_bm_ff[j];
         end
      end
   end

   // three restoring dividers, one quotient bit per stage
   logic [ROOT_W-1:0] root;
   logic [DIV_W-1:0]  dvd [3];
   q3_type            dv_rem_ff [DV_STEPS+1];
   q3_type            dv_low_ff [DV_STEPS+1];
   q3_type            dv_q_ff   [DV_STEPS+1];
   logic [ROOT_W-1:0] dv_s_ff   [DV_STEPS+1];

   always_comb begin
      root = sq_r_ff[SQ_STEPS][ROOT_W-1:0];
      for (int i = 0; i < 3; i++) begin
         dvd[i] = DIV_W'({sq_bm_ff[SQ_STEPS][i], {FRAC_W{1'b0}}}) + DIV_W'(root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= QUO_W'(dvd[i][DIV_W-1:QUO_W]);
            dv_low_ff[0][i] <= dvd[i][QUO_W-1:0];
            dv_q_ff[0][i]   <= '0;
         end
         dv_s_ff[0] <= root;
      end
   end

   for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
      logic [QUO_W:0] t    [3];
      q3_type         rem_in, q_in;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            t[i] = {dv_rem_ff[j][i], dv_low_ff[j][i][QUO_W-1]};
            if (t[i] >= {1'b0, dv_s_ff[j]}) begin
               rem_in[i] = QUO_W'(t[i] - {1'b0, dv_s_ff[j]});
               q_in[i]   = {dv_q_ff[j][i][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[i] = t[i][QUO_W-1:0];
               q_in[i]   = {dv_q_ff[j][i][QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_rem_ff[j+1] <= rem_in;
            dv_q_ff[j+1]   <= q_in;
            for (int i = 0; i < 3; i++) begin
               dv_low_ff[j+1][i] <= {dv_low_ff[j][i][QUO_W-2:0], 1'b0};
            end
            dv_s_ff[j+1] <= dv_s_ff[j];
         end
      end
   end

   // saturate, restore sign, zero column
   localparam logic [QUO_W-1:0] ONE_Q = QUO_W'(1) << FRAC_W;
   logic [QUO_W-1:0]  sat;
   logic [DATA_W-1:0] w;
   vec3_type          e_in, e_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sat = (dv_q_ff[DV_STEPS][i] > ONE_Q) ? ONE_Q : dv_q_ff[DV_STEPS][i];
         w   = DATA_W'(sat);
         if (zero_ff[LAST-1]) begin
            e_in[i] = '0;
         end else if (sgn_ff[LAST-1][i]) begin
            e_in[i] = ~w + 1'b1;
         end else begin
            e_in[i] = w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_ff <= e_in;
      end
   end

   assign out_vec        = e_ff;
   assign out_flow.valid = vld_ff[LAST];
   assign out_flow.zero  = zero_ff[LAST];
   assign out_side       = side_ff[LAST];

endmodule

// ----- sv/gs3_proj.sv -----
// ----------------------------------------------------------------------------
// gs3_proj
// subtracts the projection of a column on a unit vector, six stages
// ----------------------------------------------------------------------------
module gs3_proj
   import gs3_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  vec3_type          in_v,
   input  vec3_type          in_e,
   input  wvec3_type         in_base,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output wvec3_type         out_rem,
   output logic [SIDE_W-1:0] out_side
);

   localparam int PST    = 6;
   localparam int PROD_W = 67;
   localparam int RND_W  = PROD_W - FRAC_W;
   localparam int P_W    = 35;

   // shift right by the fraction width, rounding half away from zero
   function automatic logic signed [RND_W-1:0] shr_round(input logic signed [PROD_W-1:0] x);
      logic [PROD_W-1:0] mag;
      logic [RND_W-1:0]  q;
      mag = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
      q   = RND_W'((mag + (PROD_W'(1) << (FRAC_W - 1))) >> FRAC_W);
      return x[PROD_W-1] ? -$signed(q) : $signed(q);
   endfunction

   logic [PST-1:0]             vld_ff;
   logic [PST-1:0][SIDE_W-1:0] side_ff;
   vec3_type                   e_ff    [PST];
   wvec3_type                  base_ff [PST];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[PST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff    <= {side_ff[PST-2:0], in_side};
         e_ff[0]    <= in_e;
         base_ff[0] <= in_base;
         for (int k = 1; k < PST; k++) begin
            e_ff[k]    <= e_ff[k-1];
            base_ff[k] <= base_ff[k-1];
         end
      end
   end

   logic signed [2*DATA_W-1:0] pr0_ff [3];
   logic signed [PROD_W-1:0]   sum_ff;
   logic signed [P_W-1:0]      p_ff;
   logic signed [PROD_W-1:0]   pr1_ff [3];
   logic signed [WIDE_W-1:0]   cmp_ff [3];
   wvec3_type                  r_ff;
   logic signed [RND_W-1:0]    p_rnd;
   logic signed [RND_W-1:0]    c_rnd  [3];

   always_comb begin
      p_rnd = shr_round(sum_ff);
      for (int i = 0; i < 3; i++) begin
         c_rnd[i] = shr_round(pr1_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            pr0_ff[i] <= $signed(in_v[i]) * $signed(in_e[i]);
         end
         sum_ff <= PROD_W'(pr0_ff[0]) + PROD_W'(pr0_ff[1]) + PROD_W'(pr0_ff[2]);
         p_ff   <= P_W'(p_rnd);
         for (int i = 0; i < 3; i++) begin
            pr1_ff[i] <= p_ff * $signed(e_ff[2][i]);
            cmp_ff[i] <= WIDE_W'(c_rnd[i]);
            r_ff[i]   <= WIDE_W'($signed(base_ff[4][i]) - cmp_ff[i]);
         end
      end
   end

   assign out_valid = vld_ff[PST-1];
   assign out_rem   = r_ff;
   assign out_side  = side_ff[PST-1];

endmodule

// ----- sv/gram_schmidt_3x3_orthonormalize_core.sv -----
// ----------------------------------------------------------------------------
// gram_schmidt_3x3_orthonormalize_core
// classical gram-schmidt on a 3x3 q16.16 matrix, q2.30 orthonormal result
// ----------------------------------------------------------------------------
// usage
//   req_* carries one matrix as three columns; a transaction is taken on a
//   clock edge with req_valid high and req_stall low. rsp_* returns the unit
//   columns and rsp_degenerate, taken with rsp_valid high and rsp_stall low.
//   one result per matrix, in order; matrices are independent.
// structure and throughput
//   the path from request to response: input register, three normaliser
//   pipelines of 70 stages each (32 square root and 31 divider stages
//   inside), three projection pipelines of 6 stages and the output register.
//   one matrix per cycle is accepted while the response side keeps up.
// stall
//   all stages move together; while a response waits under rsp_stall the
//   whole pipeline holds and req_stall is high. empty stages are filled as
//   the pipeline moves, so nothing is lost or repeated.
// reset
//   synchronous, clears the valid bits of every stage; no other state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gram_schmidt_3x3_orthonormalize_core
   import gs3_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_in_c0_x,
   input  logic signed [DATA_W-1:0] req_in_c0_y,
   input  logic signed [DATA_W-1:0] req_in_c0_z,
   input  logic signed [DATA_W-1:0] req_in_c1_x,
   input  logic signed [DATA_W-1:0] req_in_c1_y,
   input  logic signed [DATA_W-1:0] req_in_c1_z,
   input  logic signed [DATA_W-1:0] req_in_c2_x,
   input  logic signed [DATA_W-1:0] req_in_c2_y,
   input  logic signed [DATA_W-1:0] req_in_c2_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_out_c0_x,
   output logic signed [DATA_W-1:0] rsp_out_c0_y,
   output logic signed [DATA_W-1:0] rsp_out_c0_z,
   output logic signed [DATA_W-1:0] rsp_out_c1_x,
   output logic signed [DATA_W-1:0] rsp_out_c1_y,
   output logic signed [DATA_W-1:0] rsp_out_c1_z,
   output logic signed [DATA_W-1:0] rsp_out_c2_x,
   output logic signed [DATA_W-1:0] rsp_out_c2_y,
   output logic signed [DATA_W-1:0] rsp_out_c2_z,
   output logic                     rsp_degenerate
);

   typedef struct packed {
      vec3_type c1;
      vec3_type c2;
   } side0_type;

   typedef struct packed {
      vec3_type e0;
      logic     z0;
      vec3_type c2;
   } side1_type;

   typedef struct packed {
      vec3_type e0;
      logic     z0;
      vec3_type e1;
      logic     z1;
      vec3_type c2;
   } side2_type;

   typedef struct packed {
      vec3_type e0;
      logic     z0;
      vec3_type e1;
      logic     z1;
   } side3_type;

   function automatic wvec3_type widen(input vec3_type v);
      wvec3_type w;
      for (int i = 0; i < 3; i++) begin
         w[i] = WIDE_W'($signed(v[i]));
      end
      return w;
   endfunction

   logic advance;

   // input register
   logic     in_vld_ff;
   vec3_type c0_ff, c1_ff, c2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (advance) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c0_ff <= {req_in_c0_z, req_in_c0_y, req_in_c0_x};
         c1_ff <= {req_in_c1_z, req_in_c1_y, req_in_c1_x};
         c2_ff <= {req_in_c2_z, req_in_c2_y, req_in_c2_x};
      end
   end

   // column 0
   gs3_flow_type n0_flow;
   vec3_type     n0_vec;
   side0_type    n0_side;

   gs3_norm #(.SIDE_W($bits(side0_type))) u_norm0 (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (in_vld_ff),
      .in_vec   (widen(c0_ff)),
      .in_side  (side0_type'{c1: c1_ff, c2: c2_ff}),
      .out_flow (n0_flow),
      .out_vec  (n0_vec),
      .out_side (n0_side)
   );

   // column 1
   logic      p1_valid;
   wvec3_type p1_rem;
   side1_type p1_side;

   gs3_proj #(.SIDE_W($bits(side1_type))) u_proj1 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (n0_flow.valid),
      .in_v      (n0_side.c1),
      .in_e      (n0_vec),
      .in_base   (widen(n0_side.c1)),
      .in_side   (side1_type'{e0: n0_vec, z0: n0_flow.zero, c2: n0_side.c2}),
      .out_valid (p1_valid),
      .out_rem   (p1_rem),
      .out_side  (p1_side)
   );

   gs3_flow_type n1_flow;
   vec3_type     n1_vec;
   side1_type    n1_side;

   gs3_norm #(.SIDE_W($bits(side1_type))) u_norm1 (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (p1_valid),
      .in_vec   (p1_rem),
      .in_side  (p1_side),
      .out_flow (n1_flow),
      .out_vec  (n1_vec),
      .out_side (n1_side)
   );

   // column 2, both projections taken against the original column
   logic      p2a_valid;
   wvec3_type p2a_rem;
   side2_type p2a_side;

   gs3_proj #(.SIDE_W($bits(side2_type))) u_proj2a (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (n1_flow.valid),
      .in_v      (n1_side.c2),
      .in_e      (n1_side.e0),
      .in_base   (widen(n1_side.c2)),
      .in_side   (side2_type'{e0: n1_side.e0, z0: n1_side.z0,
                              e1: n1_vec, z1: n1_flow.zero, c2: n1_side.c2}),
      .out_valid (p2a_valid),
      .out_rem   (p2a_rem),
      .out_side  (p2a_side)
   );

   logic      p2b_valid;
   wvec3_type p2b_rem;
   side3_type p2b_side;

   gs3_proj #(.SIDE_W($bits(side3_type))) u_proj2b (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p2a_valid),
      .in_v      (p2a_side.c2),
      .in_e      (p2a_side.e1),
      .in_base   (p2a_rem),
      .in_side   (side3_type'{e0: p2a_side.e0, z0: p2a_side.z0,
                              e1: p2a_side.e1, z1: p2a_side.z1}),
      .out_valid (p2b_valid),
      .out_rem   (p2b_rem),
      .out_side  (p2b_side)
   );

   gs3_flow_type n2_flow;
   vec3_type     n2_vec;
   side3_type    n2_side;

   gs3_norm #(.SIDE_W($bits(side3_type))) u_norm2 (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (p2b_valid),
      .in_vec   (p2b_rem),
      .in_side  (p2b_side),
      .out_flow (n2_flow),
      .out_vec  (n2_vec),
      .out_side (n2_side)
   );

   // output register
   logic     rsp_valid_ff;
   vec3_type e0_ff, e1_ff, e2_ff;
   logic     degen_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= n2_flow.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e0_ff    <= n2_side.e0;
         e1_ff    <= n2_side.e1;
         e2_ff    <= n2_vec;
         degen_ff <= n2_side.z0 || n2_side.z1 || n2_flow.zero;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_c0_x   = e0_ff[0];
   assign rsp_out_c0_y   = e0_ff[1];
   assign rsp_out_c0_z   = e0_ff[2];
   assign rsp_out_c1_x   = e1_ff[0];
   assign rsp_out_c1_y   = e1_ff[1];
   assign rsp_out_c1_z   = e1_ff[2];
   assign rsp_out_c2_x   = e2_ff[0];
   assign rsp_out_c2_y   = e2_ff[1];
   assign rsp_out_c2_z   = e2_ff[2];
   assign rsp_degenerate = degen_ff;

   // a waiting response freezes the whole pipeline
   `GS3_ASSERT_IMPLY(a_stall_holds_input, clock, reset, rsp_valid && rsp_stall, req_stall)

   // an accepted transaction lands in the input register
   `GS3_ASSERT_NEXT(a_accept_loads, clock, reset, req_valid && !req_stall, in_vld_ff)

   // without the flag the first unit column cannot be all zero
   `GS3_ASSERT_IMPLY(a_col0_nonzero, clock, reset, rsp_valid && !rsp_degenerate, rsp_out_c0_x != 0 || rsp_out_c0_y != 0 || rsp_out_c0_z != 0)

endmodule

// ----- tb/sv/gram_schmidt_3x3_orthonormalize_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gram_schmidt_3x3_orthonormalize_core_test
// self-checking bench: directed and random matrices go in through the
// request port, the scoreboard predicts the q2.30 orthonormal columns and
// the degenerate flag, and every response is compared in order
// ----------------------------------------------------------------------------
module gram_schmidt_3x3_orthonormalize_core_test;
   import gs3_pkg::*;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef word_type matrix_type [9];
   typedef longint wide3_type [3];

   typedef struct {
      matrix_type unit;
      bit         degen;
   } ortho_type;

   class ortho_scoreboard;
      ortho_type pending[$];
      int        errors = 0;

      function longint unsigned mag(longint v);
         return v < 0 ? -v : v;
      endfunction

      function longint rnd_shift(longint v, int k);
         longint unsigned m;
         m = (mag(v) + (64'd1 << (k - 1))) >> k;
         return v < 0 ? -longint'(m) : longint'(m);
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned res, bt;
         res = 0;
         bt = 64'd1 << 62;
         while (bt > n) bt >>= 2;
         while (bt != 0) begin
            if (n >= res + bt) begin
               n -= res + bt;
               res = (res >> 1) + bt;
            end else begin
               res >>= 1;
            end
            bt >>= 2;
         end
         return res;
      endfunction

      function bit to_unit(input wide3_type a, output wide3_type e);
         longint unsigned m, n, s, t, q;
         longint b[3];
         int k;
         m = 0;
         n = 0;
         k = 0;
         for (int i = 0; i < 3; i++) if (mag(a[i]) > m) m = mag(a[i]);
         if (m == 0) begin
            e = '{0, 0, 0};
            return 1;
         end
         if (m >= (64'd1 << 30)) begin
            while ((m >> k) >= (64'd1 << 30)) k++;
            for (int i = 0; i < 3; i++) begin
               t = mag(a[i]) >> k;
               b[i] = a[i] < 0 ? -longint'(t) : longint'(t);
            end
         end else begin
            while ((m << k) < (64'd1 << 29)) k++;
            for (int i = 0; i < 3; i++) b[i] = a[i] <<< k;
         end
         for (int i = 0; i < 3; i++) n += mag(b[i]) * mag(b[i]);
         s = int_sqrt(n);
         for (int i = 0; i < 3; i++) begin
            q = ((mag(b[i]) << 30) + (s >> 1)) / s;
            if (q > (64'd1 << 30)) q = 64'd1 << 30;
            e[i] = b[i] < 0 ? -longint'(q) : longint'(q);
         end
         return 0;
      endfunction

      // classical form: projection always taken against the original column
      function void strip(input wide3_type v, input wide3_type e, inout wide3_type r);
         longint p;
         p = rnd_shift(v[0] * e[0] + v[1] * e[1] + v[2] * e[2], 30);
         for (int i = 0; i < 3; i++) r[i] -= rnd_shift(p * e[i], 30);
      endfunction

      function void note_request(matrix_type m);
         wide3_type v[3], e[3], r;
         ortho_type res;
         for (int c = 0; c < 3; c++)
            for (int i = 0; i < 3; i++) v[c][i] = longint'(m[c * 3 + i]);
         res.degen = to_unit(v[0], e[0]);
         r = v[1];
         strip(v[1], e[0], r);
         res.degen |= to_unit(r, e[1]);
         r = v[2];
         strip(v[2], e[0], r);
         strip(v[2], e[1], r);
         res.degen |= to_unit(r, e[2]);
         for (int c = 0; c < 3; c++)
            for (int i = 0; i < 3; i++) res.unit[c * 3 + i] = word_type'(e[c][i]);
         pending.insert(pending.size(), res);
      endfunction

      function void check_response(ortho_type got);
         ortho_type want;
         string names[9] = '{"out_c0_x", "out_c0_y", "out_c0_z", "out_c1_x", "out_c1_y",
                             "out_c1_z", "out_c2_x", "out_c2_y", "out_c2_z"};
         if (pending.size() == 0) begin
            $error("response with nothing outstanding");
            errors++;
            return;
         end
         want = pending.pop_front();
         for (int i = 0; i < 9; i++)
            if (got.unit[i] !== want.unit[i]) begin
               $error("%s expected %h actual %h", names[i], want.unit[i], got.unit[i]);
               errors++;
            end
         if (got.degen !== want.degen) begin
            $error("degenerate expected %b actual %b", want.degen, got.degen);
            errors++;
         end
      endfunction
   endclass

   logic     clock = 0;
   logic     reset = 1;
   logic     req_valid = 0;
   logic     req_stall;
   word_type req_in_c0_x = 0, req_in_c0_y = 0, req_in_c0_z = 0;
   word_type req_in_c1_x = 0, req_in_c1_y = 0, req_in_c1_z = 0;
   word_type req_in_c2_x = 0, req_in_c2_y = 0, req_in_c2_z = 0;
   logic     rsp_valid;
   logic     rsp_stall = 0;
   word_type rsp_out_c0_x, rsp_out_c0_y, rsp_out_c0_z;
   word_type rsp_out_c1_x, rsp_out_c1_y, rsp_out_c1_z;
   word_type rsp_out_c2_x, rsp_out_c2_y, rsp_out_c2_z;
   logic     rsp_degenerate;

   ortho_scoreboard sb = new();
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   gram_schmidt_3x3_orthonormalize_core dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);

   always @(negedge clock) begin
      ortho_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.unit = '{rsp_out_c0_x, rsp_out_c0_y, rsp_out_c0_z, rsp_out_c1_x, rsp_out_c1_y,
                      rsp_out_c1_z, rsp_out_c2_x, rsp_out_c2_y, rsp_out_c2_z};
         got.degen = rsp_degenerate;
         sb.check_response(got);
      end
   end

   // called and returning at a rising edge
   task automatic send_matrix(matrix_type m);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      {req_in_c0_x, req_in_c0_y, req_in_c0_z} <= {m[0], m[1], m[2]};
      {req_in_c1_x, req_in_c1_y, req_in_c1_z} <= {m[3], m[4], m[5]};
      {req_in_c2_x, req_in_c2_y, req_in_c2_z} <= {m[6], m[7], m[8]};
      do @(negedge clock); while (req_stall);
      sb.note_request(m);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic word_type rand_word(int sh);
      return $signed($urandom) >>> sh;
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type m;
      int mode, sh;
      word_type k0, k1;
      mode = $urandom_range(9);
      sh = $urandom_range(31);
      for (int i = 0; i < 9; i++) m[i] = rand_word(mode < 3 ? 0 : sh);
      k0 = $urandom_range(7) - 3;
      k1 = $urandom_range(7) - 3;
      case (mode)
         5: begin // nearly dependent columns
            for (int i = 0; i < 3; i++) begin
               m[3 + i] = m[i] * k0 + rand_word(28);
               m[6 + i] = m[i] * k1 + m[3 + i] + rand_word(28 + $urandom_range(3));
            end
         end
         6: begin // a zero column somewhere
            sh = $urandom_range(2);
            for (int i = 0; i < 3; i++) m[sh * 3 + i] = 0;
         end
         7: begin // exactly dependent
            for (int i = 0; i < 3; i++) m[6 + i] = m[i] * k0 + m[3 + i] * k1;
         end
         default: ;
      endcase
      return m;
   endfunction

   initial begin
      matrix_type dir[$];
      matrix_type m;
      word_type one = 32'sh0001_0000;
      word_type mx = 32'sh7fff_ffff;
      word_type mn = 32'sh8000_0000;
      dir.insert(dir.size(), '{0, 0, 0, 0, 0, 0, 0, 0, 0});
      dir.insert(dir.size(), '{one, 0, 0, 0, one, 0, 0, 0, one});
      dir.insert(dir.size(), '{mx, mx, mx, mx, mx, mx, mx, mx, mx});
      dir.insert(dir.size(), '{mn, mn, mn, mn, mn, mn, mn, mn, mn});
      dir.insert(dir.size(), '{mx, mn, mx, mn, mx, mn, mx, mn, mx});
      dir.insert(dir.size(), '{mn, 0, 0, 0, mx, 0, 0, 0, mn});
      dir.insert(dir.size(), '{1, 0, 0, 0, -1, 0, 0, 0, 1});
      dir.insert(dir.size(), '{1, 1, 1, 1, -1, 1, -1, 1, 1});
      dir.insert(dir.size(), '{-1, -1, -1, -1, -1, -1, 1, 1, 1});
      m = random_matrix();
      dir.insert(dir.size(), '{m[0], m[1], m[2], m[0], m[1], m[2], m[6], m[7], m[8]});
      dir.insert(dir.size(), '{0, 0, 0, m[3], m[4], m[5], m[6], m[7], m[8]});
      dir.insert(dir.size(), '{m[0], m[1], m[2], 0, 0, 0, m[6], m[7], m[8]});
      dir.insert(dir.size(), '{m[0], m[1], m[2], m[3], m[4], m[5], 0, 0, 0});
      dir.insert(dir.size(), '{m[0], m[1], m[2], m[3], m[4], m[5],
                               m[0] + m[3], m[1] + m[4], m[2] + m[5]});
      dir.insert(dir.size(), '{one, 0, 0, one, 1, 0, one, 1, 1});
      dir.insert(dir.size(), '{mx, 0, 0, mx, 1, 0, mx, 0, 1});
      dir.insert(dir.size(), '{one, one, 0, -one, one, 0, 0, 0, -one});
      dir.insert(dir.size(), '{3, 4, 0, 4, -3, 0, 0, 0, 5});
      dir.insert(dir.size(), '{mn, mx, 1, -1, 0, mn, mx, -1, 0});
      dir.insert(dir.size(), '{one, 2 * one, 3 * one, 2 * one, 4 * one, 6 * one + 1,
                               7, 8, 9});

      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (dir[i]) send_matrix(dir[i]);
      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = phase == 0 ? 17 : phase == 1 ? 58 : 0;
         rx_idle_pct = phase == 0 ? 58 : phase == 1 ? 17 : 0;
         for (int n = 0; n < 510; n++) send_matrix(random_matrix());
         // hold the sender until everything outstanding is back
         drain();
         @(posedge clock);
      end
      repeat (250) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #4ms;
      $display("FAILURE");
      $finish;
   end

endmodule
